// ===== rtl/bsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the base64 stream decoder
// Result kinds, character codes, the sextet table and the job record that
// travels from the front end through the job queue to the result stage.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// Default depth of the job queue between front end and result stage.
	localparam int JOB_DEPTH = 4;

	// One job holds everything a single input item gives rise to.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        has_final;
		logic [1:0]  final_kind;
	} bsd_job_t;

	// Six-bit value of a character of either alphabet; bit 6 set means the
	// character belongs to neither.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = 7'd64;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2D || c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h5F || c == 8'h2F) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, both alphabets
//
// Channel  Direction  Handshake         Payload
// input    in         push / full       char_code, char_present, end_of_text
// result   out        empty / pop       byte_out, kind, is_last
//
// A character beat is decoded in the cycle it is taken; up to one item per
// cycle while the queue has room. Each item yields up to four results, sent
// one per cycle from the queue head while pops keep up, so the result side
// sets the sustained rate when groups complete often. Reset is asynchronous
// and clears group state, queue and output register. Either side may stall
// without stopping the other until the queue of QUEUE_DEPTH jobs fills.
// ----------------------------------------------------------------------------
module base64_stream_decoder import bsd_pkg::*; #(
	parameter int QUEUE_DEPTH = JOB_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       char_present,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] byte_out,
	output logic [1:0] kind,
	output logic       is_last
);

	logic     job_push;
	bsd_job_t job;
	logic     q_full;
	logic     head_pop;
	bsd_job_t head;
	logic     head_valid;

	assign full = q_full;

	bsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.char_present (char_present),
		.end_of_text  (end_of_text),
		.push         (push),
		.q_full       (q_full),
		.job_push     (job_push),
		.job          (job)
	);

	bsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (job_push),
		.wr_job     (job),
		.full       (q_full),
		.rd         (head_pop),
		.head       (head),
		.head_valid (head_valid)
	);

	bsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.byte_out   (byte_out),
		.kind       (kind),
		.is_last    (is_last)
	);

endmodule

// ===== rtl/bsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_front: character intake and group decoding
// Takes one character beat per cycle unless the queue is full, keeps group
// and run state, writes one job per item yielding bytes or end-of-text result.
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       char_present,
	input  logic       end_of_text,
	input  logic       push,
	input  logic       q_full,
	output logic       job_push,
	output bsd_job_t   job
);

	localparam logic [1:0] MODE_RUN  = 2'd0;
	localparam logic [1:0] MODE_STOP = 2'd1;
	localparam logic [1:0] MODE_FAIL = 2'd2;

	logic [1:0]  mode_q, mode_n;
	logic [23:0] bits_q, bits_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [2:0]  pad_q, pad_n;
	logic        accept;

	assign accept = push && !q_full;

	always_comb begin
		logic [6:0] sv;
		logic [2:0] marker;
		sv     = sextet_of(char_code);
		marker = 3'd0;
		mode_n = mode_q;
		bits_n = bits_q;
		cnt_n  = cnt_q;
		pad_n  = pad_q;
		job.bits       = 24'd0;
		job.nbytes     = 2'd0;
		job.has_final  = 1'b0;
		job.final_kind = KIND_OK;

		if (char_present && mode_q == MODE_RUN) begin
			if (char_code == CHAR_PAD) begin
				if (cnt_q == 3'd0) begin
					mode_n = MODE_STOP;
				end else begin
					pad_n  = pad_q + 3'd1;
					bits_n = {bits_q[17:0], 6'd0};
					cnt_n  = cnt_q + 3'd1;
				end
			end else if (pad_q != 3'd0 || sv[6]) begin
				mode_n = MODE_FAIL;
				bits_n = 24'd0;
				cnt_n  = 3'd0;
				pad_n  = 3'd0;
			end else begin
				bits_n = {bits_q[17:0], sv[5:0]};
				cnt_n  = cnt_q + 3'd1;
			end

			if (mode_n == MODE_RUN && cnt_n >= 3'd4) begin
				if (pad_n > 3'd2) begin
					mode_n = MODE_FAIL;
				end else begin
					job.bits   = bits_n;
					job.nbytes = 2'(3'd3 - pad_n);
					if (pad_n != 3'd0) begin
						mode_n = MODE_STOP;
					end
				end
				bits_n = 24'd0;
				cnt_n  = 3'd0;
				pad_n  = 3'd0;
			end
		end

		if (end_of_text) begin
			if (mode_n == MODE_RUN && cnt_n != 3'd0) begin
				if (cnt_n < 3'd2) begin
					mode_n = MODE_FAIL;
				end else begin
					marker = (pad_n != 3'd0) ? pad_n : 3'(3'd4 - cnt_n);
					if (marker > 3'd2) begin
						mode_n = MODE_FAIL;
					end else begin
						// A short group is left-aligned as if padded out to four.
						job.bits   = (cnt_n == 3'd3) ? {bits_n[17:0], 6'd0}
						                             : {bits_n[11:0], 12'd0};
						job.nbytes = 2'(3'd3 - marker);
						if (pad_n != 3'd0) begin
							mode_n = MODE_STOP;
						end
					end
				end
			end
			job.has_final  = 1'b1;
			job.final_kind = (mode_n == MODE_RUN || mode_n == MODE_STOP) ? KIND_OK : KIND_BAD;
			mode_n = MODE_RUN;
			bits_n = 24'd0;
			cnt_n  = 3'd0;
			pad_n  = 3'd0;
		end
	end

	assign job_push = accept && (job.nbytes != 2'd0 || job.has_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RUN;
			bits_q <= 24'd0;
			cnt_q  <= 3'd0;
			pad_q  <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			bits_q <= bits_n;
			cnt_q  <= cnt_n;
			pad_q  <= pad_n;
		end
	end

endmodule

// ===== rtl/bsd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_fifo: job queue
// Short register queue that decouples the front end from the result stage;
// the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module bsd_fifo import bsd_pkg::*; #(
	parameter int DEPTH = JOB_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  bsd_job_t wr_job,
	output logic     full,
	input  logic     rd,
	output bsd_job_t head,
	output logic     head_valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bsd_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != CW'(0));
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd))
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && !head_valid))
		else $error("job queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count beyond depth");

endmodule

// ===== rtl/bsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_back: result stage
// Walks the head job into the output register one result per cycle while pops
// keep up, and retires the job with its last result.
// ----------------------------------------------------------------------------
module bsd_back import bsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bsd_job_t   head,
	input  logic       head_valid,
	output logic       head_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] byte_out,
	output logic [1:0] kind,
	output logic       is_last
);

	logic [1:0] step_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       load;
	logic [2:0] total;
	logic       last_step;
	logic       is_byte;
	logic [7:0] sel_byte;

	assign load      = head_valid && (!out_valid_q || pop);
	assign total     = {1'b0, head.nbytes} + {2'd0, head.has_final};
	assign last_step = ({1'b0, step_q} == total - 3'd1);
	assign is_byte   = ({1'b0, step_q} < {1'b0, head.nbytes});
	assign head_pop  = load && last_step;

	always_comb begin
		unique case (step_q)
			2'd0: sel_byte = head.bits[23:16];
			2'd1: sel_byte = head.bits[15:8];
			2'd2: sel_byte = head.bits[7:0];
			2'd3: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= last_step ? 2'd0 : step_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= is_byte ? sel_byte : 8'd0;
			kind_q <= is_byte ? KIND_BYTE : head.final_kind;
			last_q <= !is_byte;
		end
	end

	assign empty    = !out_valid_q;
	assign byte_out = byte_q;
	assign kind     = kind_q;
	assign is_last  = last_q;

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> step_q == 2'd0)
		else $error("result step left over without a job");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, step_q} < total)
		else $error("result step beyond the job");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == (kind_q != KIND_BYTE)))
		else $error("final mark and result kind disagree");

endmodule
